/* hw/rtl/owbm_pkg.sv */
// shared types, codes and tables of the one-wire bus master
`default_nettype none
package owbm_pkg;

   // command codes
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_RESET = 3'd1;
   localparam logic [2:0] CMD_WRITE = 3'd2;
   localparam logic [2:0] CMD_READ  = 3'd3;
   localparam logic [2:0] CMD_TOUCH = 3'd4;
   localparam logic [2:0] CMD_ROM   = 3'd5;

   localparam int ROM_BYTES = 8;
   localparam logic [7:0] READ_ROM_CODE = 8'h33;
   localparam logic [7:0] CRC_POLY      = 8'h8C;

   // sequencer phases, one-hot
   typedef enum logic [7:0] {
      PH_IDLE = 8'b0000_0001,
      PH_RPRE = 8'b0000_0010,
      PH_RLOW = 8'b0000_0100,
      PH_RSMP = 8'b0000_1000,
      PH_RREC = 8'b0001_0000,
      PH_SLOW = 8'b0010_0000,
      PH_SSMP = 8'b0100_0000,
      PH_SREC = 8'b1000_0000
   } phase_type;

   // slot kinds
   typedef enum logic [1:0] {
      K_READ = 2'd0,
      K_W1   = 2'd1,
      K_W0   = 2'd2
   } kind_type;

   // timing interval names
   typedef enum logic [3:0] {
      T_A = 4'd0, T_B = 4'd1, T_C = 4'd2, T_D = 4'd3, T_E = 4'd4,
      T_F = 4'd5, T_G = 4'd6, T_H = 4'd7, T_I = 4'd8, T_J = 4'd9
   } interval_type;

   // one result beat
   typedef struct packed {
      logic        drive_low;
      logic        busy_res;
      logic        done_res;
      logic        presence;
      logic [7:0]  received_byte;
      logic [63:0] rom_id;
      logic        rom_ok;
   } result_type;

   // interval length in microseconds
   function automatic logic [8:0] slot_time(logic use_std, interval_type idx);
      logic [8:0] t;
      t = 9'd0;
      if (use_std) begin
         unique case (idx)
            T_A: t = 9'd6;
            T_B: t = 9'd64;
            T_C: t = 9'd60;
            T_D: t = 9'd10;
            T_E: t = 9'd9;
            T_F: t = 9'd55;
            T_G: t = 9'd0;
            T_H: t = 9'd480;
            T_I: t = 9'd70;
            T_J: t = 9'd410;
            default: t = 9'd0;
         endcase
      end else begin
         unique case (idx)
            T_A: t = 9'd2;
            T_B: t = 9'd8;
            T_C: t = 9'd8;
            T_D: t = 9'd8;
            T_E: t = 9'd1;
            T_F: t = 9'd7;
            T_G: t = 9'd3;
            T_H: t = 9'd70;
            T_I: t = 9'd9;
            T_J: t = 9'd40;
            default: t = 9'd0;
         endcase
      end
      return t;
   endfunction

   // reflected crc-8 over one byte
   function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] v);
      logic [7:0] c;
      c = crc ^ v;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/owbm_req_if.sv */
// request channel: command, data byte and sampled line level
`default_nettype none
interface owbm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [7:0] data_byte;
   logic       line_level;

   modport source (output valid, output command, output data_byte, output line_level,
                   input ready);
   modport sink   (input valid, input command, input data_byte, input line_level,
                   output ready);
endinterface
`default_nettype wire

/* hw/rtl/owbm_rsp_if.sv */
// response channel: bus drive, status, received byte and rom id
`default_nettype none
interface owbm_rsp_if;
   logic        valid;
   logic        ready;
   logic        drive_low;
   logic        busy_res;
   logic        done_res;
   logic        presence;
   logic [7:0]  received_byte;
   logic [63:0] rom_id;
   logic        rom_ok;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output presence, output received_byte, output rom_id, output rom_ok,
                   input ready);
   modport sink   (input valid, input drive_low, input busy_res, input done_res,
                   input presence, input received_byte, input rom_id, input rom_ok,
                   output ready);
endinterface
`default_nettype wire

/* hw/rtl/owbm_engine.sv */
// slot sequencer: state registers and the per-tick next-state logic
`default_nettype none
module owbm_engine (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step_en,
   input  wire logic [2:0]          cmd,
   input  wire logic [7:0]          data,
   input  wire logic                line,
   input  wire logic                std_speed,
   output owbm_pkg::result_type     result
);

   owbm_pkg::phase_type phase_ff, phase_in;
   logic [8:0]  timer_ff, timer_in;
   logic [2:0]  bit_count_ff, bit_count_in;
   logic [3:0]  byte_count_ff, byte_count_in;
   logic [7:0]  tx_ff, tx_in;
   logic [7:0]  rx_ff, rx_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [63:0] rom_ff, rom_in;
   logic [7:0]  crc_ff, crc_in;
   logic        pres_ff, pres_in;
   logic        rok_ff, rok_in;

   owbm_pkg::phase_type ph_start;
   owbm_pkg::kind_type  kind_a, kind_b, kind_c;
   logic        start;
   logic        drive, busy, done;
   logic [8:0]  gap;
   logic [3:0]  lane_wide;
   logic [2:0]  lane;

   // slot kind from the command, next bit and byte position
   function automatic owbm_pkg::kind_type slot_kind(logic [2:0] ac, logic b,
                                                   logic [3:0] byc);
      owbm_pkg::kind_type k;
      priority if (ac == owbm_pkg::CMD_READ) begin
         k = owbm_pkg::K_READ;
      end else if (ac == owbm_pkg::CMD_TOUCH) begin
         k = b ? owbm_pkg::K_READ : owbm_pkg::K_W0;
      end else if (ac == owbm_pkg::CMD_ROM && byc != 4'd0) begin
         k = owbm_pkg::K_READ;
      end else begin
         k = b ? owbm_pkg::K_W1 : owbm_pkg::K_W0;
      end
      return k;
   endfunction

   // interval length; read rom always runs at standard timing
   function automatic logic [8:0] tval(logic [2:0] ac, logic sp, owbm_pkg::interval_type i);
      return owbm_pkg::slot_time((ac == owbm_pkg::CMD_ROM) || sp, i);
   endfunction

   // one tick of the sequencer
   always_comb begin
      phase_in      = phase_ff;
      timer_in      = timer_ff;
      bit_count_in  = bit_count_ff;
      byte_count_in = byte_count_ff;
      tx_in         = tx_ff;
      rx_in         = rx_ff;
      cmd_in        = cmd_ff;
      rom_in        = rom_ff;
      crc_in        = crc_ff;
      pres_in       = pres_ff;
      rok_in        = rok_ff;
      drive         = 1'b0;
      busy          = 1'b0;
      done          = 1'b0;
      kind_a        = owbm_pkg::K_READ;
      kind_b        = owbm_pkg::K_READ;
      kind_c        = owbm_pkg::K_READ;
      gap           = 9'd0;
      lane_wide     = 4'd0;
      lane          = 3'd0;
      ph_start      = phase_ff;

      // command start when idle
      start = (phase_ff == owbm_pkg::PH_IDLE) && (cmd >= owbm_pkg::CMD_RESET)
              && (cmd <= owbm_pkg::CMD_ROM);
      if (start) begin
         cmd_in        = cmd;
         bit_count_in  = 3'd0;
         byte_count_in = 4'd0;
         if (cmd == owbm_pkg::CMD_RESET) begin
            gap = tval(cmd, std_speed, owbm_pkg::T_G);
            if (gap != 9'd0) begin
               phase_in = owbm_pkg::PH_RPRE;
               timer_in = gap;
            end else begin
               phase_in = owbm_pkg::PH_RLOW;
               timer_in = tval(cmd, std_speed, owbm_pkg::T_H);
            end
         end else begin
            if (cmd == owbm_pkg::CMD_ROM) begin
               tx_in  = owbm_pkg::READ_ROM_CODE;
               rom_in = 64'd0;
               crc_in = 8'd0;
               rok_in = 1'b0;
            end else begin
               tx_in = data;
            end
            kind_a = slot_kind(cmd, tx_in[0], 4'd0);
            if (kind_a == owbm_pkg::K_W0 && cmd == owbm_pkg::CMD_TOUCH) begin
               rx_in = rx_in >> 1;
            end
            phase_in = owbm_pkg::PH_SLOW;
            timer_in = (kind_a == owbm_pkg::K_W0) ? tval(cmd, std_speed, owbm_pkg::T_C)
                                                  : tval(cmd, std_speed, owbm_pkg::T_A);
         end
      end
      ph_start = phase_in;

      // timer countdown, sampling and phase change
      if (ph_start != owbm_pkg::PH_IDLE) begin
         busy  = 1'b1;
         drive = (ph_start == owbm_pkg::PH_RLOW) || (ph_start == owbm_pkg::PH_SLOW);
         if (timer_in == 9'd1) begin
            if (ph_start == owbm_pkg::PH_RSMP) pres_in = ~line;
            if (ph_start == owbm_pkg::PH_SSMP) rx_in = {line, rx_in[7:1]};
         end
         if (timer_in != 9'd0) timer_in = timer_in - 9'd1;
         if (timer_in == 9'd0) begin
            unique case (ph_start)
               owbm_pkg::PH_RPRE: begin
                  phase_in = owbm_pkg::PH_RLOW;
                  timer_in = tval(cmd_in, std_speed, owbm_pkg::T_H);
               end
               owbm_pkg::PH_RLOW: begin
                  phase_in = owbm_pkg::PH_RSMP;
                  timer_in = tval(cmd_in, std_speed, owbm_pkg::T_I);
               end
               owbm_pkg::PH_RSMP: begin
                  phase_in = owbm_pkg::PH_RREC;
                  timer_in = tval(cmd_in, std_speed, owbm_pkg::T_J);
               end
               owbm_pkg::PH_SLOW: begin
                  kind_b = slot_kind(cmd_in, tx_in[0], byte_count_in);
                  if (kind_b == owbm_pkg::K_READ) begin
                     phase_in = owbm_pkg::PH_SSMP;
                     timer_in = tval(cmd_in, std_speed, owbm_pkg::T_E);
                  end else begin
                     phase_in = owbm_pkg::PH_SREC;
                     timer_in = (kind_b == owbm_pkg::K_W1)
                                ? tval(cmd_in, std_speed, owbm_pkg::T_B)
                                : tval(cmd_in, std_speed, owbm_pkg::T_D);
                  end
               end
               owbm_pkg::PH_SSMP: begin
                  phase_in = owbm_pkg::PH_SREC;
                  timer_in = tval(cmd_in, std_speed, owbm_pkg::T_F);
               end
               owbm_pkg::PH_SREC: begin
                  // end of a bit slot
                  if (bit_count_in != 3'd7) begin
                     bit_count_in = bit_count_in + 3'd1;
                     tx_in        = tx_in >> 1;
                     kind_c       = slot_kind(cmd_in, tx_in[0], byte_count_in);
                  end else begin
                     bit_count_in = 3'd0;
                     if (cmd_in != owbm_pkg::CMD_ROM) begin
                        phase_in = owbm_pkg::PH_IDLE;
                        done     = 1'b1;
                     end else begin
                        if (byte_count_in >= 4'd1
                            && byte_count_in <= 4'(owbm_pkg::ROM_BYTES)) begin
                           lane_wide = byte_count_in - 4'd1;
                           lane      = lane_wide[2:0];
                           for (int k = 0; k < owbm_pkg::ROM_BYTES; k++) begin
                              if (lane == 3'(k)) rom_in[k*8 +: 8] = rx_in;
                           end
                           crc_in = owbm_pkg::crc8_byte(crc_in, rx_in);
                        end
                        byte_count_in = byte_count_in + 4'd1;
                        if (byte_count_in >= 4'(owbm_pkg::ROM_BYTES + 1)) begin
                           rok_in   = (crc_in == 8'd0) && (rom_in[7:0] != 8'd0);
                           phase_in = owbm_pkg::PH_IDLE;
                           done     = 1'b1;
                        end else begin
                           kind_c = slot_kind(cmd_in, tx_in[0], byte_count_in);
                        end
                     end
                  end
                  // next slot unless the command just finished
                  if (!done) begin
                     if (kind_c == owbm_pkg::K_W0 && cmd_in == owbm_pkg::CMD_TOUCH) begin
                        rx_in = rx_in >> 1;
                     end
                     phase_in = owbm_pkg::PH_SLOW;
                     timer_in = (kind_c == owbm_pkg::K_W0)
                                ? tval(cmd_in, std_speed, owbm_pkg::T_C)
                                : tval(cmd_in, std_speed, owbm_pkg::T_A);
                  end
               end
               default: begin
                  phase_in = owbm_pkg::PH_IDLE;
                  done     = 1'b1;
               end
            endcase
         end
      end
   end

   // result of this tick
   always_comb begin
      result.drive_low     = drive;
      result.busy_res      = busy;
      result.done_res      = done;
      result.presence      = pres_in;
      result.received_byte = rx_in;
      result.rom_id        = rom_in;
      result.rom_ok        = rok_in;
   end

   // state registers advance once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= owbm_pkg::PH_IDLE;
         timer_ff      <= 9'd0;
         bit_count_ff  <= 3'd0;
         byte_count_ff <= 4'd0;
         tx_ff         <= 8'd0;
         rx_ff         <= 8'd0;
         cmd_ff        <= owbm_pkg::CMD_NONE;
         rom_ff        <= 64'd0;
         crc_ff        <= 8'd0;
         pres_ff       <= 1'b0;
         rok_ff        <= 1'b0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         timer_ff      <= timer_in;
         bit_count_ff  <= bit_count_in;
         byte_count_ff <= byte_count_in;
         tx_ff         <= tx_in;
         rx_ff         <= rx_in;
         cmd_ff        <= cmd_in;
         rom_ff        <= rom_in;
         crc_ff        <= crc_in;
         pres_ff       <= pres_in;
         rok_ff        <= rok_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/owbm_rsp_reg.sv */
// result register between the sequencer and the response channel
`default_nettype none
module owbm_rsp_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire owbm_pkg::result_type result,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic                      can_load,
   output owbm_pkg::result_type      rsp_data
);

   logic                 valid_ff, valid_in;
   owbm_pkg::result_type data_ff;

   // take a new beat when empty or when the held one leaves this cycle
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload holds until the next load
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

/* hw/rtl/one_wire_bus_master_core.sv */
// one-wire bus master core: top level
//
//  channel  dir  beat carries                                          handshake
//  req      in   command, data_byte, line_level (one microsecond tick) valid/ready
//  rsp      out  drive_low, busy_res, done_res, presence,              valid/ready
//                received_byte, rom_id, rom_ok
//  csr      in   standard_speed                                        write enable
//
// One request beat per cycle while the response is not stalled; its response follows in the
// next cycle from the result register, loaded by a single combinational sequencer pass.
// Synchronous active-high reset: idle phase, counters cleared, standard timing selected.
// A stalled response blocks a new request only while the result register is full.
`default_nettype none
module one_wire_bus_master_core (
   input  wire logic  clock,
   input  wire logic  reset,
   owbm_req_if.sink   req_port,
   owbm_rsp_if.source rsp_port,
   input  wire logic  csr_write_en,
   input  wire logic  csr_write_data
);

   logic                 std_speed_ff;
   logic                 accept;
   logic                 can_load;
   owbm_pkg::result_type result;
   owbm_pkg::result_type rsp_data;

   // speed register
   always_ff @(posedge clock) begin
      if (reset) begin
         std_speed_ff <= 1'b1;
      end else if (csr_write_en) begin
         std_speed_ff <= csr_write_data;
      end
   end

   assign req_port.ready = can_load;
   assign accept         = req_port.valid && can_load;

   owbm_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step_en   (accept),
      .cmd       (req_port.command),
      .data      (req_port.data_byte),
      .line      (req_port.line_level),
      .std_speed (std_speed_ff),
      .result    (result)
   );

   owbm_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .result    (result),
      .rsp_ready (rsp_port.ready),
      .rsp_valid (rsp_port.valid),
      .can_load  (can_load),
      .rsp_data  (rsp_data)
   );

   // response payload
   assign rsp_port.drive_low     = rsp_data.drive_low;
   assign rsp_port.busy_res      = rsp_data.busy_res;
   assign rsp_port.done_res      = rsp_data.done_res;
   assign rsp_port.presence      = rsp_data.presence;
   assign rsp_port.received_byte = rsp_data.received_byte;
   assign rsp_port.rom_id        = rsp_data.rom_id;
   assign rsp_port.rom_ok        = rsp_data.rom_ok;

endmodule
`default_nettype wire

/* hw/rtl/owbm_checker.sv */
// port-level checks of the one-wire bus master core and their binding
`default_nettype none
module owbm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       drive_low,
   input wire logic       busy_res,
   input wire logic       done_res,
   input wire logic [7:0] rom_low,
   input wire logic       rom_ok
);

   // no response beat right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled beat stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // driving and finishing only happen inside an operation
   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (drive_low || done_res) |-> busy_res)
      else $error("bus driven or done outside an operation");

   // a valid rom always has a nonzero family byte
   a_rom_family: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rom_ok |-> rom_low != 8'd0)
      else $error("rom flagged valid with zero family byte");

endmodule

bind one_wire_bus_master_core owbm_checker u_owbm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .drive_low (rsp_port.drive_low),
   .busy_res  (rsp_port.busy_res),
   .done_res  (rsp_port.done_res),
   .rom_low   (rsp_port.rom_id[7:0]),
   .rom_ok    (rsp_port.rom_ok)
);
`default_nettype wire

/* tb/one_wire_bus_master_core_tb.sv */
// self-checking testbench for the one-wire bus master core, driven one microsecond tick per beat
`default_nettype none
module one_wire_bus_master_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // command codes the block must ignore
   localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
   localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

   // operation and slot lengths in ticks
   localparam int RESET_STD_US = 960;
   localparam int RESET_OD_US  = 122;
   localparam int STD_SLOT_US  = 70;
   localparam int OD_SLOT_US   = 10;
   localparam int OD_ZERO_US   = 16;

   localparam int          LONG_HOLD_CYCLES = 400;
   localparam int unsigned CYCLE_LIMIT      = 40_000;
   localparam int          MAX_REPORTS      = 40;

   typedef enum logic [1:0] {
      IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
   } idle_mode_type;

   // one request beat: one microsecond of bus time
   typedef struct packed {
      logic [2:0] command;
      logic [7:0] data_byte;
      logic       line_level;
   } tick_type;

   typedef struct {
      owbm_pkg::result_type res;
      int unsigned          stamp;
   } predicted_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic csr_write_data;

   owbm_req_if req_bus();
   owbm_rsp_if rsp_bus();

   one_wire_bus_master_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_port       (req_bus),
      .rsp_port       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   tick_type             pending_ticks[$];
   predicted_type        predicted_results[$];
   tick_type             offered_tick;
   predicted_type        predicted;
   predicted_type        oldest;
   owbm_pkg::result_type seen_beat;

   idle_mode_type idle_mode;
   int unsigned   cycle_count;
   int            error_count;
   int            hold_left;
   bit            hold_request;
   bit            gen_std;
   int            pick;

   // bus master state as predicted
   owbm_pkg::phase_type bm_phase;
   logic [8:0]          bm_timer;
   logic [2:0]          bm_bit;
   logic [3:0]          bm_byte;
   logic [7:0]          bm_tx;
   logic [7:0]          bm_rx;
   logic [2:0]          bm_cmd;
   logic [63:0]         bm_rom;
   logic [7:0]          bm_crc;
   logic                bm_presence;
   logic                bm_rom_ok;
   logic                bm_std;

   // clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic bit roll(int pct);
      return $urandom_range(99) < pct;
   endfunction

   // bitwise reflected crc-8, one data bit per step
   function automatic logic [7:0] crc_step(logic [7:0] crc, logic [7:0] v);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ v[i];
         c = {1'b0, c[7:1]};
         if (fb) c = c ^ owbm_pkg::CRC_POLY;
      end
      return c;
   endfunction

   // interval length, read rom always at standard speed
   function automatic logic [8:0] interval_us(owbm_pkg::interval_type iv);
      logic fast;
      fast = (bm_cmd != owbm_pkg::CMD_ROM) && !bm_std;
      case (iv)
         owbm_pkg::T_A: interval_us = fast ? 9'd2  : 9'd6;
         owbm_pkg::T_B: interval_us = fast ? 9'd8  : 9'd64;
         owbm_pkg::T_C: interval_us = fast ? 9'd8  : 9'd60;
         owbm_pkg::T_D: interval_us = fast ? 9'd8  : 9'd10;
         owbm_pkg::T_E: interval_us = fast ? 9'd1  : 9'd9;
         owbm_pkg::T_F: interval_us = fast ? 9'd7  : 9'd55;
         owbm_pkg::T_G: interval_us = fast ? 9'd3  : 9'd0;
         owbm_pkg::T_H: interval_us = fast ? 9'd70 : 9'd480;
         owbm_pkg::T_I: interval_us = fast ? 9'd9  : 9'd70;
         owbm_pkg::T_J: interval_us = fast ? 9'd40 : 9'd410;
         default: interval_us = 9'd0;
      endcase
   endfunction

   function automatic owbm_pkg::kind_type next_kind();
      if (bm_cmd == owbm_pkg::CMD_READ) return owbm_pkg::K_READ;
      if (bm_cmd == owbm_pkg::CMD_TOUCH) return bm_tx[0] ? owbm_pkg::K_READ : owbm_pkg::K_W0;
      if (bm_cmd == owbm_pkg::CMD_ROM && bm_byte != 4'd0) return owbm_pkg::K_READ;
      return bm_tx[0] ? owbm_pkg::K_W1 : owbm_pkg::K_W0;
   endfunction

   task automatic bus_clear();
      bm_phase    = owbm_pkg::PH_IDLE;
      bm_timer    = '0;
      bm_bit      = '0;
      bm_byte     = '0;
      bm_tx       = '0;
      bm_rx       = '0;
      bm_cmd      = owbm_pkg::CMD_NONE;
      bm_rom      = '0;
      bm_crc      = '0;
      bm_presence = 1'b0;
      bm_rom_ok   = 1'b0;
      bm_std      = 1'b1;
   endtask

   // a touched zero shifts a 0 into the receive byte as its slot opens
   task automatic open_slot();
      owbm_pkg::kind_type k;
      k = next_kind();
      if (k == owbm_pkg::K_W0 && bm_cmd == owbm_pkg::CMD_TOUCH) bm_rx = bm_rx >> 1;
      bm_phase = owbm_pkg::PH_SLOW;
      bm_timer = (k == owbm_pkg::K_W0) ? interval_us(owbm_pkg::T_C)
                                       : interval_us(owbm_pkg::T_A);
   endtask

   // end of a bit slot: next bit, next rom byte, or finished
   task automatic close_bit(output bit finished);
      int sh;
      finished = 1'b0;
      if (bm_bit < 3'd7) begin
         bm_bit = bm_bit + 3'd1;
         bm_tx  = bm_tx >> 1;
         open_slot();
      end else begin
         bm_bit = '0;
         if (bm_cmd != owbm_pkg::CMD_ROM) begin
            finished = 1'b1;
         end else begin
            if (bm_byte >= 1 && bm_byte <= owbm_pkg::ROM_BYTES) begin
               sh = (bm_byte - 1) * 8;
               bm_rom[sh +: 8] = bm_rx;
               bm_crc = crc_step(bm_crc, bm_rx);
            end
            bm_byte = bm_byte + 4'd1;
            if (bm_byte >= owbm_pkg::ROM_BYTES + 1) begin
               bm_rom_ok = (bm_crc == 8'h00) && (bm_rom[7:0] != 8'h00);
               finished  = 1'b1;
            end else begin
               open_slot();
            end
         end
      end
   endtask

   // one microsecond of the bus master
   task automatic bus_tick(input tick_type t, output owbm_pkg::result_type r);
      owbm_pkg::kind_type k;
      bit                 fin;
      r = '0;
      if (bm_phase == owbm_pkg::PH_IDLE && t.command >= owbm_pkg::CMD_RESET
          && t.command <= owbm_pkg::CMD_ROM) begin
         bm_cmd  = t.command;
         bm_bit  = '0;
         bm_byte = '0;
         if (t.command == owbm_pkg::CMD_RESET) begin
            if (interval_us(owbm_pkg::T_G) != 9'd0) begin
               bm_phase = owbm_pkg::PH_RPRE;
               bm_timer = interval_us(owbm_pkg::T_G);
            end else begin
               bm_phase = owbm_pkg::PH_RLOW;
               bm_timer = interval_us(owbm_pkg::T_H);
            end
         end else begin
            if (t.command == owbm_pkg::CMD_ROM) begin
               bm_tx     = owbm_pkg::READ_ROM_CODE;
               bm_rom    = '0;
               bm_crc    = '0;
               bm_rom_ok = 1'b0;
            end else begin
               bm_tx = t.data_byte;
            end
            open_slot();
         end
      end
      if (bm_phase != owbm_pkg::PH_IDLE) begin
         r.busy_res  = 1'b1;
         r.drive_low = (bm_phase == owbm_pkg::PH_RLOW) || (bm_phase == owbm_pkg::PH_SLOW);
         // sample points sit on the last microsecond of their interval
         if (bm_timer == 9'd1) begin
            if (bm_phase == owbm_pkg::PH_RSMP) bm_presence = !t.line_level;
            if (bm_phase == owbm_pkg::PH_SSMP) bm_rx = {t.line_level, bm_rx[7:1]};
         end
         if (bm_timer > 9'd0) bm_timer = bm_timer - 9'd1;
         if (bm_timer == 9'd0) begin
            case (bm_phase)
               owbm_pkg::PH_RPRE: begin
                  bm_phase = owbm_pkg::PH_RLOW;
                  bm_timer = interval_us(owbm_pkg::T_H);
               end
               owbm_pkg::PH_RLOW: begin
                  bm_phase = owbm_pkg::PH_RSMP;
                  bm_timer = interval_us(owbm_pkg::T_I);
               end
               owbm_pkg::PH_RSMP: begin
                  bm_phase = owbm_pkg::PH_RREC;
                  bm_timer = interval_us(owbm_pkg::T_J);
               end
               owbm_pkg::PH_SLOW: begin
                  k = next_kind();
                  if (k == owbm_pkg::K_READ) begin
                     bm_phase = owbm_pkg::PH_SSMP;
                     bm_timer = interval_us(owbm_pkg::T_E);
                  end else begin
                     bm_phase = owbm_pkg::PH_SREC;
                     bm_timer = (k == owbm_pkg::K_W1) ? interval_us(owbm_pkg::T_B)
                                                      : interval_us(owbm_pkg::T_D);
                  end
               end
               owbm_pkg::PH_SSMP: begin
                  bm_phase = owbm_pkg::PH_SREC;
                  bm_timer = interval_us(owbm_pkg::T_F);
               end
               owbm_pkg::PH_SREC: begin
                  close_bit(fin);
                  if (fin) begin
                     bm_phase    = owbm_pkg::PH_IDLE;
                     r.done_res  = 1'b1;
                  end
               end
               default: begin
                  bm_phase   = owbm_pkg::PH_IDLE;
                  r.done_res = 1'b1;
               end
            endcase
         end
      end
      r.presence      = bm_presence;
      r.received_byte = bm_rx;
      r.rom_id        = bm_rom;
      r.rom_ok        = bm_rom_ok;
   endtask

   task automatic push_tick(input logic [2:0] cmd, input logic [7:0] data, input logic line);
      tick_type t;
      t.command    = cmd;
      t.data_byte  = data;
      t.line_level = line;
      pending_ticks.push_back(t);
   endtask

   // idle bus time, now and then carrying an unused command code
   task automatic queue_idle(input int n);
      logic [2:0] cmd;
      for (int i = 0; i < n; i++) begin
         cmd = owbm_pkg::CMD_NONE;
         if ($urandom_range(5) == 0) cmd = $urandom_range(1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
         push_tick(cmd, 8'($urandom), 1'($urandom));
      end
   endtask

   // one whole operation, bus level held per slot; keep > 0 cuts it short
   task automatic queue_operation(input logic [2:0] op, input logic [7:0] data,
                                  input logic [63:0] bus_bits, input bit use_std,
                                  input int keep);
      int         lens[$];
      bit         lines[$];
      int         sent;
      logic [2:0] cmd;
      bit         zero_slot;
      if (op == owbm_pkg::CMD_RESET) begin
         lens.push_back(use_std ? RESET_STD_US : RESET_OD_US);
         lines.push_back(bus_bits[0]);
      end else if (op == owbm_pkg::CMD_ROM) begin
         for (int i = 0; i < 8; i++) begin
            lens.push_back(STD_SLOT_US);
            lines.push_back(1'b1);
         end
         for (int i = 0; i < 64; i++) begin
            lens.push_back(STD_SLOT_US);
            lines.push_back(bus_bits[i]);
         end
      end else begin
         for (int i = 0; i < 8; i++) begin
            zero_slot = (op == owbm_pkg::CMD_WRITE || op == owbm_pkg::CMD_TOUCH) && !data[i];
            lens.push_back(use_std ? STD_SLOT_US : (zero_slot ? OD_ZERO_US : OD_SLOT_US));
            lines.push_back(bus_bits[i]);
         end
      end
      sent = 0;
      foreach (lens[s]) begin
         for (int u = 0; u < lens[s]; u++) begin
            if (keep == 0 || sent < keep) begin
               // later commands land while busy and must be ignored
               cmd = owbm_pkg::CMD_NONE;
               if (sent == 0) cmd = op;
               else if ($urandom_range(4) == 0) cmd = 3'($urandom_range(7));
               push_tick(cmd, (sent == 0) ? data : 8'($urandom), lines[s]);
            end
            sent++;
         end
      end
      if (keep == 0) queue_idle($urandom_range(3));
   endtask

   // eight rom bytes with a matching crc byte, optionally broken
   function automatic logic [63:0] rom_image(bit zero_family, bit corrupt);
      logic [63:0] img;
      logic [7:0]  c;
      int          flip;
      img = {$urandom, $urandom};
      if (zero_family) img[7:0] = 8'h00;
      c = 8'h00;
      for (int i = 0; i < 7; i++) c = crc_step(c, img[8*i +: 8]);
      img[63:56] = c;
      if (corrupt) begin
         flip = $urandom_range(63);
         img[flip] = ~img[flip];
      end
      return img;
   endfunction

   // wait until the sender is empty and every result is back
   task automatic drain();
      while (pending_ticks.size() != 0 || req_bus.valid || predicted_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_speed(input bit use_std);
      drain();
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= use_std;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      gen_std = use_std;
      @(negedge clock);
   endtask

   task automatic check_field(input string field, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (act_v !== exp_v) begin
         if (error_count < MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, exp_v, act_v);
         error_count++;
      end
   endtask

   // cycle count and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         hold_left <= LONG_HOLD_CYCLES;
      end
   end

   // tick driver: predicts each accepted beat, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         bus_clear();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            bus_tick(offered_tick, predicted.res);
            predicted.stamp = cycle_count;
            predicted_results.push_back(predicted);
         end
         if (csr_write_en) bm_std = csr_write_data;
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_ticks.size() != 0 &&
                !roll((idle_mode == IDLE_SENDER) ? 52 : (idle_mode == IDLE_BOTH) ? 33 : 0)) begin
               offered_tick = pending_ticks.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.command    <= offered_tick.command;
               req_bus.data_byte  <= offered_tick.data_byte;
               req_bus.line_level <= offered_tick.line_level;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: each beat against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_beat.drive_low     = rsp_bus.drive_low;
            seen_beat.busy_res      = rsp_bus.busy_res;
            seen_beat.done_res      = rsp_bus.done_res;
            seen_beat.presence      = rsp_bus.presence;
            seen_beat.received_byte = rsp_bus.received_byte;
            seen_beat.rom_id        = rsp_bus.rom_id;
            seen_beat.rom_ok        = rsp_bus.rom_ok;
            if (predicted_results.size() == 0 || predicted_results[0].stamp == cycle_count) begin
               if (error_count < MAX_REPORTS)
                  $display("%0t ns: result beat with none expected, actual %p", $time, seen_beat);
               error_count++;
            end else begin
               oldest = predicted_results.pop_front();
               check_field("drive_low", oldest.res.drive_low, seen_beat.drive_low);
               check_field("busy_res", oldest.res.busy_res, seen_beat.busy_res);
               check_field("done_res", oldest.res.done_res, seen_beat.done_res);
               check_field("presence", oldest.res.presence, seen_beat.presence);
               check_field("received_byte", oldest.res.received_byte, seen_beat.received_byte);
               check_field("rom_id", oldest.res.rom_id, seen_beat.rom_id);
               check_field("rom_ok", oldest.res.rom_ok, seen_beat.rom_ok);
            end
         end
         rsp_bus.ready <= (hold_left == 0) &&
            !roll((idle_mode == IDLE_RECEIVER) ? 52 : (idle_mode == IDLE_BOTH) ? 33 : 0);
      end
   end

   // stimulus
   initial begin
      reset              = 1'b1;
      csr_write_en       = 1'b0;
      csr_write_data     = 1'b0;
      req_bus.valid      = 1'b0;
      req_bus.command    = owbm_pkg::CMD_NONE;
      req_bus.data_byte  = 8'h00;
      req_bus.line_level = 1'b1;
      rsp_bus.ready      = 1'b0;
      idle_mode          = IDLE_NONE;
      cycle_count        = 0;
      error_count        = 0;
      hold_request       = 1'b0;
      gen_std            = 1'b1;
      pick               = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // standard timing from reset: ignored codes, then a write cut short after one slot
      idle_mode = IDLE_NONE;
      push_tick(CMD_UNUSED_6, 8'hFF, 1'b0);
      push_tick(CMD_UNUSED_7, 8'h00, 1'b1);
      queue_operation(owbm_pkg::CMD_WRITE, 8'h5A, '1, gen_std, STD_SLOT_US);
      // hold the receiver off while the driver keeps offering beats
      hold_request = 1'b1;
      @(negedge clock);
      @(negedge clock);
      hold_request = 1'b0;

      // overdrive from here; the unfinished write goes on at the new speed
      set_speed(1'b0);
      queue_idle(100);
      queue_operation(owbm_pkg::CMD_RESET, 8'h00, 64'h0, gen_std, 0);
      drain();

      // sender idling
      idle_mode = IDLE_SENDER;
      queue_operation(owbm_pkg::CMD_RESET, 8'h00, '1, gen_std, 0);
      queue_operation(owbm_pkg::CMD_WRITE, 8'hA5, 64'h0, gen_std, 0);
      drain();

      // receiver stalling
      idle_mode = IDLE_RECEIVER;
      queue_operation(owbm_pkg::CMD_READ, 8'h00, {$urandom, $urandom}, gen_std, 0);
      queue_operation(owbm_pkg::CMD_TOUCH, 8'h5A, {$urandom, $urandom}, gen_std, 0);
      drain();

      // both sides idling: one random operation, then a read rom cut short
      idle_mode = IDLE_BOTH;
      pick = $urandom_range(3);
      queue_operation((pick == 0) ? owbm_pkg::CMD_RESET :
                      (pick == 1) ? owbm_pkg::CMD_WRITE :
                      (pick == 2) ? owbm_pkg::CMD_READ : owbm_pkg::CMD_TOUCH,
                      8'($urandom), {$urandom, $urandom}, gen_std, 0);
      // read rom keeps standard timing while overdrive is selected
      queue_operation(owbm_pkg::CMD_ROM, 8'h00, rom_image(1'b0, 1'b0), gen_std, 80);

      drain();
      repeat (4) @(negedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire
